// ===== src/csgs_pkg.sv =====
// shared types, codes and helpers for the color sort gate sequencer
`timescale 1ns / 1ps

package csgs_pkg;

	// request kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_SORT  = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_RESET = 2'd3
	} kind_t;

	// color classes
	localparam logic [2:0] COLOR_UNKNOWN = 3'd0;
	localparam logic [2:0] COLOR_RED     = 3'd1;
	localparam logic [2:0] COLOR_GREEN   = 3'd2;
	localparam logic [2:0] COLOR_BLUE    = 3'd3;
	localparam logic [2:0] COLOR_WHITE   = 3'd4;
	localparam logic [2:0] COLOR_BLACK   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_HOME   = 3'd0;
	localparam logic [2:0] CFG_RED    = 3'd1;
	localparam logic [2:0] CFG_GREEN  = 3'd2;
	localparam logic [2:0] CFG_BLUE   = 3'd3;
	localparam logic [2:0] CFG_WHITE  = 3'd4;
	localparam logic [2:0] CFG_BLACK  = 3'd5;
	localparam logic [2:0] CFG_TRAVEL = 3'd6;
	localparam logic [2:0] CFG_HOLD   = 3'd7;

	// configuration reset values
	localparam logic [7:0]  HOME_RST   = 8'd90;
	localparam logic [7:0]  RED_RST    = 8'd30;
	localparam logic [7:0]  GREEN_RST  = 8'd60;
	localparam logic [7:0]  BLUE_RST   = 8'd120;
	localparam logic [7:0]  WHITE_RST  = 8'd150;
	localparam logic [7:0]  BLACK_RST  = 8'd180;
	localparam logic [15:0] TRAVEL_RST = 16'd500;
	localparam logic [15:0] HOLD_RST   = 16'd300;

	localparam logic [7:0]  SERVO_MAX   = 8'd180;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// sequencer phases, one-hot
	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_WAIT   = 6'b000010,
		PH_MOVE   = 6'b000100,
		PH_HOLD   = 6'b001000,
		PH_RETURN = 6'b010000,
		PH_EMERG  = 6'b100000
	} phase_t;

	// phase codes as reported on the result
	localparam logic [2:0] PHASE_CODE_IDLE   = 3'd0;
	localparam logic [2:0] PHASE_CODE_WAIT   = 3'd1;
	localparam logic [2:0] PHASE_CODE_MOVE   = 3'd2;
	localparam logic [2:0] PHASE_CODE_HOLD   = 3'd3;
	localparam logic [2:0] PHASE_CODE_RETURN = 3'd4;
	localparam logic [2:0] PHASE_CODE_EMERG  = 3'd5;

	// fifo control from the sequencer
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [2:0] wdata;
	} fifo_ctl_t;

	// fifo status to the sequencer
	typedef struct packed {
		logic       not_empty;
		logic       full;
		logic [2:0] head;
	} fifo_stat_t;

	// result fields from the sequencer
	typedef struct packed {
		logic [7:0] servo_angle;
		logic       accepted;
		logic [2:0] phase;
		logic [2:0] active_color;
		logic       busy;
	} seq_res_t;

	function automatic logic [7:0] sat_angle(input logic [7:0] a);
		return (a > SERVO_MAX) ? SERVO_MAX : a;
	endfunction

	function automatic logic [2:0] phase_code(input phase_t p);
		logic [2:0] c;
		unique case (p)
			PH_IDLE:   c = PHASE_CODE_IDLE;
			PH_WAIT:   c = PHASE_CODE_WAIT;
			PH_MOVE:   c = PHASE_CODE_MOVE;
			PH_HOLD:   c = PHASE_CODE_HOLD;
			PH_RETURN: c = PHASE_CODE_RETURN;
			PH_EMERG:  c = PHASE_CODE_EMERG;
			default:   c = PHASE_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== src/csgs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module csgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/csgs_job_fifo.sv =====
// ring fifo of queued color jobs with head prefetch
`timescale 1ns / 1ps

module csgs_job_fifo #(
	parameter int DEPTH = 8,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csgs_pkg::fifo_ctl_t   ctl,
	output csgs_pkg::fifo_stat_t  stat,
	output logic [3:0]            count_next
);

	logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W+3:0] cnt_ext;
	logic             ram_we;
	logic [2:0]       ram_rdata;
	logic             byp_q;
	logic [2:0]       byp_data_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// next pointers and fill count
	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		cnt_d    = cnt_q;
		if (ctl.clear) begin
			rd_ptr_d = '0;
			wr_ptr_d = '0;
			cnt_d    = '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_d = ptr_inc(wr_ptr_q);
			end
			if (ctl.pop) begin
				rd_ptr_d = ptr_inc(rd_ptr_q);
			end
			if (ctl.push && !ctl.pop) begin
				cnt_d = cnt_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				cnt_d = cnt_q - 1'b1;
			end
		end
	end

	assign ram_we = ctl.push && !ctl.clear;

	// pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			byp_q    <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			cnt_q    <= cnt_d;
			byp_q    <= ram_we && (wr_ptr_q == rd_ptr_d);
		end
	end

	// forward a write that lands on the next head slot
	always_ff @(posedge clk) begin
		byp_data_q <= ctl.wdata;
	end

	// job storage, read address is the next read pointer so the head is prefetched
	csgs_ram #(
		.WIDTH (3),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (ctl.wdata),
		.raddr (rd_ptr_d),
		.rdata (ram_rdata)
	);

	assign cnt_ext         = {4'b0000, cnt_d};
	assign count_next      = cnt_ext[3:0];
	assign stat.not_empty  = (cnt_q != '0);
	assign stat.full       = (cnt_q == CNT_W'(DEPTH));
	assign stat.head       = byp_q ? byp_data_q : ram_rdata;

endmodule

// ===== src/csgs_sequencer.sv =====
// configuration registers and the phase gate sequencer
`timescale 1ns / 1ps

module csgs_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [1:0]            kind,
	input  logic [2:0]            color,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  csgs_pkg::fifo_stat_t  fifo_stat,
	output csgs_pkg::fifo_ctl_t   fifo_ctl,
	output csgs_pkg::seq_res_t    res
);

	logic [7:0]  home_q, red_q, green_q, blue_q, white_q, black_q;
	logic [15:0] travel_q, hold_q;

	csgs_pkg::phase_t phase_q, phase_d;
	logic [2:0]  job_color_q, job_color_d;
	logic [7:0]  target_q, target_d;
	logic [15:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [7:0]  servo_q, servo_d;
	logic [2:0]  req_color;
	logic [7:0]  head_angle;
	logic        accepted;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q   <= csgs_pkg::HOME_RST;
			red_q    <= csgs_pkg::RED_RST;
			green_q  <= csgs_pkg::GREEN_RST;
			blue_q   <= csgs_pkg::BLUE_RST;
			white_q  <= csgs_pkg::WHITE_RST;
			black_q  <= csgs_pkg::BLACK_RST;
			travel_q <= csgs_pkg::TRAVEL_RST;
			hold_q   <= csgs_pkg::HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csgs_pkg::CFG_HOME:   home_q   <= cfg_data[7:0];
				csgs_pkg::CFG_RED:    red_q    <= cfg_data[7:0];
				csgs_pkg::CFG_GREEN:  green_q  <= cfg_data[7:0];
				csgs_pkg::CFG_BLUE:   blue_q   <= cfg_data[7:0];
				csgs_pkg::CFG_WHITE:  white_q  <= cfg_data[7:0];
				csgs_pkg::CFG_BLACK:  black_q  <= cfg_data[7:0];
				csgs_pkg::CFG_TRAVEL: travel_q <= cfg_data;
				csgs_pkg::CFG_HOLD:   hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// out of range colors queue as unknown
	assign req_color = (color > csgs_pkg::COLOR_BLACK) ? csgs_pkg::COLOR_UNKNOWN : color;

	// angle lookup for the job at the fifo head
	always_comb begin
		unique case (fifo_stat.head)
			csgs_pkg::COLOR_RED:   head_angle = red_q;
			csgs_pkg::COLOR_GREEN: head_angle = green_q;
			csgs_pkg::COLOR_BLUE:  head_angle = blue_q;
			csgs_pkg::COLOR_WHITE: head_angle = white_q;
			csgs_pkg::COLOR_BLACK: head_angle = black_q;
			default:               head_angle = home_q;
		endcase
	end

	assign elapsed_inc = (elapsed_q == csgs_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	// next state for one request
	always_comb begin
		phase_d        = phase_q;
		job_color_d    = job_color_q;
		target_d       = target_q;
		elapsed_d      = elapsed_q;
		servo_d        = servo_q;
		accepted       = 1'b0;
		fifo_ctl.push  = 1'b0;
		fifo_ctl.pop   = 1'b0;
		fifo_ctl.clear = 1'b0;
		fifo_ctl.wdata = req_color;
		if (go) begin
			unique case (csgs_pkg::kind_t'(kind))
				csgs_pkg::KIND_TICK: begin
					unique case (phase_q)
						csgs_pkg::PH_IDLE: begin
							if (fifo_stat.not_empty) begin
								fifo_ctl.pop = 1'b1;
								job_color_d  = fifo_stat.head;
								target_d     = head_angle;
								elapsed_d    = '0;
								phase_d      = csgs_pkg::PH_WAIT;
							end
						end
						csgs_pkg::PH_WAIT: begin
							elapsed_d = elapsed_inc;
							if (elapsed_inc >= travel_q) begin
								phase_d = csgs_pkg::PH_MOVE;
							end
						end
						csgs_pkg::PH_MOVE: begin
							servo_d   = csgs_pkg::sat_angle(target_q);
							elapsed_d = '0;
							phase_d   = csgs_pkg::PH_HOLD;
						end
						csgs_pkg::PH_HOLD: begin
							elapsed_d = elapsed_inc;
							if (elapsed_inc >= hold_q) begin
								phase_d = csgs_pkg::PH_RETURN;
							end
						end
						csgs_pkg::PH_RETURN: begin
							servo_d     = csgs_pkg::sat_angle(home_q);
							job_color_d = csgs_pkg::COLOR_UNKNOWN;
							phase_d     = csgs_pkg::PH_IDLE;
						end
						default: ;
					endcase
				end
				csgs_pkg::KIND_SORT: begin
					if (phase_q != csgs_pkg::PH_EMERG && !fifo_stat.full) begin
						fifo_ctl.push = 1'b1;
						accepted      = 1'b1;
					end
				end
				csgs_pkg::KIND_STOP: begin
					servo_d        = csgs_pkg::sat_angle(home_q);
					job_color_d    = csgs_pkg::COLOR_UNKNOWN;
					fifo_ctl.clear = 1'b1;
					phase_d        = csgs_pkg::PH_EMERG;
				end
				csgs_pkg::KIND_RESET: begin
					servo_d = csgs_pkg::sat_angle(home_q);
					phase_d = csgs_pkg::PH_IDLE;
				end
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= csgs_pkg::PH_IDLE;
			job_color_q <= csgs_pkg::COLOR_UNKNOWN;
			target_q    <= csgs_pkg::HOME_RST;
			elapsed_q   <= '0;
			servo_q     <= csgs_pkg::HOME_RST;
		end else begin
			phase_q     <= phase_d;
			job_color_q <= job_color_d;
			target_q    <= target_d;
			elapsed_q   <= elapsed_d;
			servo_q     <= servo_d;
		end
	end

	// result fields taken after the update
	assign res.servo_angle  = servo_d;
	assign res.accepted     = accepted;
	assign res.phase        = csgs_pkg::phase_code(phase_d);
	assign res.active_color = job_color_d;
	assign res.busy         = (phase_d != csgs_pkg::PH_IDLE);

endmodule

// ===== src/color_sort_gate_sequencer.sv =====
// top level of the color sort gate sequencer
//
// Usage: requests enter on in_valid/in_ready with kind (tick, sort, stop,
// reset) and color. Each request yields exactly one result on
// out_valid/out_ready carrying the servo angle, whether a sort was queued,
// the phase, the active job color, the number of queued jobs and busy.
// A request passes one input register, then the update and result
// register, before its result shows on out_valid. Throughput is one
// request per cycle while the receiver does not stall; the update of
// sequencer, config lookup and job fifo is combinational between the
// two registers. The job fifo keeps its head prefetched from the ram so
// that a dequeue never waits.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at the
// next edge and must be made while no request is in flight.
// Reset (arst_n low) homes the servo to 90 degrees, empties the fifo,
// sets phase idle and restores all configuration defaults.
// When the receiver stalls, the result is held and one more request is
// buffered in the input register, after which in_ready drops.
`timescale 1ns / 1ps

module color_sort_gate_sequencer #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [2:0]  color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  servo_angle,
	output logic        accepted,
	output logic [2:0]  phase,
	output logic [2:0]  active_color,
	output logic [3:0]  queued_jobs,
	output logic        busy_res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic [2:0]           color_s1;
	logic                 go;
	logic                 valid_s2;
	logic [7:0]           servo_s2;
	logic                 accepted_s2;
	logic [2:0]           phase_s2;
	logic [2:0]           color_s2;
	logic [3:0]           queued_s2;
	logic                 busy_s2;
	csgs_pkg::fifo_ctl_t  fifo_ctl;
	csgs_pkg::fifo_stat_t fifo_stat;
	csgs_pkg::seq_res_t   res;
	logic [3:0]           count_next;

	// the held request moves on when the result slot is free or draining
	assign go       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			color_s1 <= color;
		end
	end

	csgs_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.kind      (kind_s1),
		.color     (color_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_stat (fifo_stat),
		.fifo_ctl  (fifo_ctl),
		.res       (res)
	);

	csgs_job_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fifo_ctl),
		.stat       (fifo_stat),
		.count_next (count_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			servo_s2    <= res.servo_angle;
			accepted_s2 <= res.accepted;
			phase_s2    <= res.phase;
			color_s2    <= res.active_color;
			queued_s2   <= count_next;
			busy_s2     <= res.busy;
		end
	end

	assign out_valid    = valid_s2;
	assign servo_angle  = servo_s2;
	assign accepted     = accepted_s2;
	assign phase        = phase_s2;
	assign active_color = color_s2;
	assign queued_jobs  = queued_s2;
	assign busy_res     = busy_s2;

endmodule

// ===== bench/tb_color_sort_gate_sequencer.sv =====
// self-checking testbench for the color sort gate sequencer
`timescale 1ns / 1ps

module tb_color_sort_gate_sequencer;

	localparam int FIFO_DEPTH  = 8;
	localparam int MAX_REPORTS = 10;
	localparam int MAX_GAP     = 19;

	// one result as seen on the output side
	typedef struct packed {
		logic [7:0] servo_angle;
		logic       accepted;
		logic [2:0] phase;
		logic [2:0] active_color;
		logic [3:0] queued_jobs;
		logic       busy;
	} gate_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [2:0]  color;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  servo_angle;
	logic        accepted;
	logic [2:0]  phase;
	logic [2:0]  active_color;
	logic [3:0]  queued_jobs;
	logic        busy_res;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// shadow of the configuration registers, angles indexed by color code
	logic [7:0]  angle_reg [0:5];
	logic [15:0] travel_reg;
	logic [15:0] hold_reg;

	// shadow of the sequencer and job ring
	logic [2:0]  phase_now;
	logic [2:0]  job_now;
	logic [7:0]  target_now;
	logic [7:0]  servo_now;
	logic [15:0] ticks_now;
	logic [2:0]  job_ring [0:FIFO_DEPTH-1];
	int          ring_rd;
	int          ring_wr;
	int          ring_fill;

	gate_result_t pending_results[$];
	int           fail_count = 0;
	int           results_seen = 0;
	int           results_paced = 0;
	int           rx_hold = 0;
	bit           send_quiet = 1'b0;
	bit           recv_quiet = 1'b0;

	color_sort_gate_sequencer #(.QUEUE_DEPTH(FIFO_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.color(color),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.servo_angle(servo_angle),
		.accepted(accepted),
		.phase(phase),
		.active_color(active_color),
		.queued_jobs(queued_jobs),
		.busy_res(busy_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hard stop in case the handshake hangs
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [7:0] limit_angle(input logic [7:0] a);
		return (a > csgs_pkg::SERVO_MAX) ? csgs_pkg::SERVO_MAX : a;
	endfunction

	function automatic string show_result(input gate_result_t r);
		return $sformatf("angle=%0d acc=%0d phase=%0d color=%0d jobs=%0d busy=%0d",
			r.servo_angle, r.accepted, r.phase, r.active_color, r.queued_jobs, r.busy);
	endfunction

	// state after reset
	task automatic clear_model();
		angle_reg[csgs_pkg::COLOR_UNKNOWN] = csgs_pkg::HOME_RST;
		angle_reg[csgs_pkg::COLOR_RED]     = csgs_pkg::RED_RST;
		angle_reg[csgs_pkg::COLOR_GREEN]   = csgs_pkg::GREEN_RST;
		angle_reg[csgs_pkg::COLOR_BLUE]    = csgs_pkg::BLUE_RST;
		angle_reg[csgs_pkg::COLOR_WHITE]   = csgs_pkg::WHITE_RST;
		angle_reg[csgs_pkg::COLOR_BLACK]   = csgs_pkg::BLACK_RST;
		travel_reg = csgs_pkg::TRAVEL_RST;
		hold_reg   = csgs_pkg::HOLD_RST;
		phase_now  = csgs_pkg::PHASE_CODE_IDLE;
		job_now    = csgs_pkg::COLOR_UNKNOWN;
		target_now = csgs_pkg::HOME_RST;
		servo_now  = csgs_pkg::HOME_RST;
		ticks_now  = '0;
		ring_rd    = 0;
		ring_wr    = 0;
		ring_fill  = 0;
	endtask

	// advance the shadow state by one request and return the result it yields
	function automatic gate_result_t predict_gate(input csgs_pkg::kind_t k,
			input logic [2:0] c_in);
		gate_result_t r;
		logic [2:0]   c;
		c = (c_in > csgs_pkg::COLOR_BLACK) ? csgs_pkg::COLOR_UNKNOWN : c_in;
		r.accepted = 1'b0;
		case (k)
			csgs_pkg::KIND_TICK: begin
				case (phase_now)
					csgs_pkg::PHASE_CODE_IDLE: begin
						if (ring_fill != 0) begin
							job_now    = job_ring[ring_rd];
							ring_rd    = (ring_rd + 1) % FIFO_DEPTH;
							ring_fill  = ring_fill - 1;
							target_now = angle_reg[job_now];
							ticks_now  = '0;
							phase_now  = csgs_pkg::PHASE_CODE_WAIT;
						end
					end
					csgs_pkg::PHASE_CODE_WAIT: begin
						if (ticks_now != csgs_pkg::ELAPSED_MAX)
							ticks_now = ticks_now + 16'd1;
						if (ticks_now >= travel_reg)
							phase_now = csgs_pkg::PHASE_CODE_MOVE;
					end
					csgs_pkg::PHASE_CODE_MOVE: begin
						servo_now = limit_angle(target_now);
						ticks_now = '0;
						phase_now = csgs_pkg::PHASE_CODE_HOLD;
					end
					csgs_pkg::PHASE_CODE_HOLD: begin
						if (ticks_now != csgs_pkg::ELAPSED_MAX)
							ticks_now = ticks_now + 16'd1;
						if (ticks_now >= hold_reg)
							phase_now = csgs_pkg::PHASE_CODE_RETURN;
					end
					csgs_pkg::PHASE_CODE_RETURN: begin
						servo_now = limit_angle(angle_reg[csgs_pkg::COLOR_UNKNOWN]);
						job_now   = csgs_pkg::COLOR_UNKNOWN;
						phase_now = csgs_pkg::PHASE_CODE_IDLE;
					end
					default: ;
				endcase
			end
			csgs_pkg::KIND_SORT: begin
				if (phase_now != csgs_pkg::PHASE_CODE_EMERG && ring_fill < FIFO_DEPTH) begin
					job_ring[ring_wr] = c;
					ring_wr    = (ring_wr + 1) % FIFO_DEPTH;
					ring_fill  = ring_fill + 1;
					r.accepted = 1'b1;
				end
			end
			csgs_pkg::KIND_STOP: begin
				servo_now = limit_angle(angle_reg[csgs_pkg::COLOR_UNKNOWN]);
				job_now   = csgs_pkg::COLOR_UNKNOWN;
				ring_fill = 0;
				ring_rd   = 0;
				ring_wr   = 0;
				phase_now = csgs_pkg::PHASE_CODE_EMERG;
			end
			default: begin
				servo_now = limit_angle(angle_reg[csgs_pkg::COLOR_UNKNOWN]);
				phase_now = csgs_pkg::PHASE_CODE_IDLE;
			end
		endcase
		r.servo_angle  = servo_now;
		r.phase        = phase_now;
		r.active_color = job_now;
		r.queued_jobs  = 4'(ring_fill);
		r.busy         = (phase_now != csgs_pkg::PHASE_CODE_IDLE);
		return r;
	endfunction

	// drop valid and wait until every predicted result has been delivered
	task automatic wait_drained();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic set_register(input logic [2:0] idx, input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			csgs_pkg::CFG_TRAVEL: travel_reg = value;
			csgs_pkg::CFG_HOLD:   hold_reg = value;
			default:              angle_reg[idx] = value[7:0];
		endcase
	endtask

	// send one request, predicting its result on acceptance
	task automatic send_request(input csgs_pkg::kind_t k, input logic [2:0] c);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		color    <= c;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_gate(k, c));
	endtask

	// output stall, drawn anew after every delivered result
	always @(negedge clk) begin
		if (results_seen != results_paced) begin
			results_paced = results_seen;
			rx_hold = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else
			out_ready <= 1'b1;
	end

	// compare every delivered result with the oldest prediction
	always @(posedge clk) begin : check_result
		gate_result_t want;
		gate_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {servo_angle, accepted, phase, active_color, queued_jobs, busy_res};
			results_seen = results_seen + 1;
			if (pending_results.size() == 0) begin
				fail_count = fail_count + 1;
				if (fail_count <= MAX_REPORTS)
					$display("%t unexpected result: %s", $realtime, show_result(got));
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count = fail_count + 1;
					if (fail_count <= MAX_REPORTS)
						$display("%t mismatch: expected %s, got %s",
							$realtime, show_result(want), show_result(got));
				end
			end
		end
	end

	// default angles, full queue, refused request, reset keeping the job color
	task automatic test_reset_defaults();
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_RED);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_GREEN);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_BLUE);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_WHITE);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_BLACK);
		send_request(csgs_pkg::KIND_SORT, 3'd6);
		send_request(csgs_pkg::KIND_SORT, 3'd7);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_BLUE);
		send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_BLACK);
		send_request(csgs_pkg::KIND_RESET, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
	endtask

	// stop locks out requests and ticks, repeated stop, then reset unlocks
	task automatic test_emergency();
		send_request(csgs_pkg::KIND_STOP, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_RED);
		send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_STOP, csgs_pkg::COLOR_WHITE);
		send_request(csgs_pkg::KIND_RESET, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_GREEN);
		send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_RESET, csgs_pkg::COLOR_UNKNOWN);
	endtask

	// angles beyond the servo range with zero delays
	task automatic test_angle_extremes();
		set_register(csgs_pkg::CFG_HOME, 16'd181);
		set_register(csgs_pkg::CFG_RED, 16'd255);
		set_register(csgs_pkg::CFG_GREEN, 16'd180);
		set_register(csgs_pkg::CFG_BLUE, 16'd0);
		set_register(csgs_pkg::CFG_WHITE, 16'd179);
		set_register(csgs_pkg::CFG_BLACK, 16'd1);
		set_register(csgs_pkg::CFG_TRAVEL, 16'd0);
		set_register(csgs_pkg::CFG_HOLD, 16'd0);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_RED);
		send_request(csgs_pkg::KIND_SORT, 3'd7);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_BLUE);
		repeat (15) send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
	endtask

	// longest travel delay, then longest hold time
	task automatic test_delay_extremes();
		set_register(csgs_pkg::CFG_TRAVEL, 16'hFFFF);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_GREEN);
		repeat (4) send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_RESET, csgs_pkg::COLOR_UNKNOWN);
		set_register(csgs_pkg::CFG_TRAVEL, 16'd1);
		set_register(csgs_pkg::CFG_HOLD, 16'hFFFF);
		send_request(csgs_pkg::KIND_SORT, csgs_pkg::COLOR_BLACK);
		repeat (6) send_request(csgs_pkg::KIND_TICK, csgs_pkg::COLOR_UNKNOWN);
		send_request(csgs_pkg::KIND_RESET, csgs_pkg::COLOR_UNKNOWN);
	endtask

	// mixed traffic over several register settings
	task automatic test_random_traffic(input int total);
		int              per_setting;
		int              counted;
		int              since_drain;
		int              pick;
		csgs_pkg::kind_t k;
		per_setting = total / 6;
		since_drain = 0;
		for (int s = 0; s < 6; s++) begin
			set_register(csgs_pkg::CFG_HOME, 16'($urandom_range(0, 200)));
			set_register(csgs_pkg::CFG_RED, 16'($urandom_range(0, 200)));
			set_register(csgs_pkg::CFG_GREEN, 16'($urandom_range(0, 200)));
			set_register(csgs_pkg::CFG_BLUE, 16'($urandom_range(0, 200)));
			set_register(csgs_pkg::CFG_WHITE, 16'($urandom_range(0, 255)));
			set_register(csgs_pkg::CFG_BLACK, 16'($urandom_range(0, 255)));
			set_register(csgs_pkg::CFG_TRAVEL, 16'($urandom_range(0, 6)));
			set_register(csgs_pkg::CFG_HOLD, 16'($urandom_range(0, 6)));
			send_quiet = (s == 0) || ($urandom_range(0, 3) == 0);
			recv_quiet = (s == 0) || ($urandom_range(0, 3) == 0);
			counted = 0;
			while (counted < per_setting) begin
				// in emergency most traffic is ignored, so leave it soon
				if (phase_now == csgs_pkg::PHASE_CODE_EMERG) begin
					if ($urandom_range(0, 2) == 0)
						k = csgs_pkg::KIND_RESET;
					else
						k = csgs_pkg::kind_t'($urandom_range(0, 3));
				end else begin
					counted = counted + 1;
					pick = $urandom_range(0, 99);
					if (pick < 55)
						k = csgs_pkg::KIND_TICK;
					else if (pick < 94)
						k = csgs_pkg::KIND_SORT;
					else if (pick < 97)
						k = csgs_pkg::KIND_STOP;
					else
						k = csgs_pkg::KIND_RESET;
				end
				send_request(k, 3'($urandom_range(0, 7)));
				since_drain = since_drain + 1;
				if (since_drain == 150) begin
					since_drain = 0;
					wait_drained();
				end
			end
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = csgs_pkg::KIND_TICK;
		color     = csgs_pkg::COLOR_UNKNOWN;
		cfg_we    = 1'b0;
		cfg_index = csgs_pkg::CFG_HOME;
		cfg_data  = '0;
		clear_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_emergency();
		test_angle_extremes();
		test_delay_extremes();
		test_random_traffic(1350);

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			fail_count = fail_count + 1;
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/csgs_pkg.sv
src/csgs_ram.sv
src/csgs_job_fifo.sv
src/csgs_sequencer.sv
src/color_sort_gate_sequencer.sv
bench/tb_color_sort_gate_sequencer.sv
